### design/tlprs_pkg.sv
// types and constants shared by the scheduler core
package tlprs_pkg;

    localparam int ID_W   = 6;
    localparam int TICK_W = 32;
    localparam int RUN_W  = 48;

    localparam int MAX_PROCS_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        KIND_ENQUEUE  = 2'd0,
        KIND_YIELD    = 2'd1,
        KIND_BLOCK    = 2'd2,
        KIND_SCHEDULE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   proc_id;
        logic              high_priority;
        logic [TICK_W-1:0] run_ticks;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  picked_id;
        logic             from_low;
        logic             queue_full;
        logic [RUN_W-1:0] run_total;
    } result_t;

endpackage

### design/two_level_priority_rr_scheduler_core.sv
// two-queue strict priority scheduler with per-process runtime table
//
//   channel | direction | handshake                   | payload
//   item    | in        | item_valid / item_ready     | tlprs_pkg::item_t
//   result  | out       | result_valid / result_ready | tlprs_pkg::result_t
//
// each item passes ST_IDLE, which takes it and reads the runtime table and both
// queue heads, then ST_EXEC, which adds, saturates and writes back the runtime and
// pushes or pops a queue; item_ready is low in ST_EXEC. after reset a clearing pass
// zeroes the runtime table with item_ready low. one result register sits on the output:
// a new item is taken while a result still waits, and ST_EXEC holds until it is free.
module two_level_priority_rr_scheduler_core #(
    parameter int MAX_PROCS   = tlprs_pkg::MAX_PROCS_DEF,
    parameter int QUEUE_DEPTH = tlprs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tlprs_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_ready,
    output tlprs_pkg::result_t result
);

    localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = QW + 1;
    localparam int RW = tlprs_pkg::RUN_W;
    localparam int IW = tlprs_pkg::ID_W;

    // storage
    logic [RW-1:0] rt_mem [MAX_PROCS];
    logic [IW-1:0] hq_mem [QUEUE_DEPTH];
    logic [IW-1:0] lq_mem [QUEUE_DEPTH];

    tlprs_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]      clr_idx_reg, clr_idx_next;
    tlprs_pkg::item_t   item_reg;
    logic [RW-1:0]      rt_rd_reg;
    logic [IW-1:0]      hq_rd_reg;
    logic [IW-1:0]      lq_rd_reg;
    logic [QW-1:0]      hhead_reg, hhead_next;
    logic [CW-1:0]      hcnt_reg, hcnt_next;
    logic [QW-1:0]      lhead_reg, lhead_next;
    logic [CW-1:0]      lcnt_reg, lcnt_next;
    logic               res_valid_reg, res_valid_next;
    tlprs_pkg::result_t res_reg;
    tlprs_pkg::result_t res_next;

    logic          accept;
    logic          fire;
    logic          clr_last;
    logic          in_id_ok;
    logic [AW-1:0] rd_addr;

    logic          is_push, is_rt, is_sched;
    logic          id_ok;
    logic [RW:0]   sum_wide;
    logic [RW-1:0] sum_sat;
    logic [QW-1:0] tgt_head;
    logic [CW-1:0] tgt_cnt;
    logic          tgt_full;
    logic [SW-1:0] slot_wide;
    logic [QW-1:0] slot;
    logic          pop_high, pop_low;

    logic          rt_we;
    logic [AW-1:0] rt_wa;
    logic [RW-1:0] rt_wd;
    logic          hq_we, lq_we;

    assign clr_last = (clr_idx_reg == AW'(MAX_PROCS - 1));
    assign accept   = item_valid && item_ready;

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            tlprs_pkg::ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_last)
                begin
                    state_next = tlprs_pkg::ST_IDLE;
                end
            end
            tlprs_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = tlprs_pkg::ST_EXEC;
                end
            end
            tlprs_pkg::ST_EXEC:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    state_next = tlprs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlprs_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            tlprs_pkg::ST_IDLE: item_ready = 1'b1;
            tlprs_pkg::ST_EXEC: fire = !res_valid_reg || result_ready;
            default:
            begin
                item_ready = 1'b0;
                fire       = 1'b0;
            end
        endcase
    end

    // read address for the incoming beat
    assign in_id_ok = ($unsigned(32'(item.proc_id)) < $unsigned(MAX_PROCS));
    assign rd_addr  = in_id_ok ? AW'(item.proc_id) : '0;

    // update datapath, works on the registered item and read data
    always_comb
    begin
        is_push  = (item_reg.kind == tlprs_pkg::KIND_ENQUEUE) ||
                   (item_reg.kind == tlprs_pkg::KIND_YIELD);
        is_rt    = (item_reg.kind == tlprs_pkg::KIND_YIELD) ||
                   (item_reg.kind == tlprs_pkg::KIND_BLOCK);
        is_sched = (item_reg.kind == tlprs_pkg::KIND_SCHEDULE);
        id_ok    = ($unsigned(32'(item_reg.proc_id)) < $unsigned(MAX_PROCS));

        sum_wide = {1'b0, rt_rd_reg} + (RW + 1)'(item_reg.run_ticks);
        sum_sat  = sum_wide[RW] ? {RW{1'b1}} : sum_wide[RW-1:0];

        tgt_head  = item_reg.high_priority ? hhead_reg : lhead_reg;
        tgt_cnt   = item_reg.high_priority ? hcnt_reg : lcnt_reg;
        tgt_full  = (tgt_cnt == CW'(QUEUE_DEPTH));
        slot_wide = SW'(tgt_head) + SW'(tgt_cnt);
        if (slot_wide >= SW'(QUEUE_DEPTH))
        begin
            slot_wide = slot_wide - SW'(QUEUE_DEPTH);
        end
        slot = slot_wide[QW-1:0];

        pop_high = is_sched && (hcnt_reg != '0);
        pop_low  = is_sched && (hcnt_reg == '0) && (lcnt_reg != '0);

        res_next.found      = pop_high || pop_low;
        res_next.picked_id  = pop_high ? hq_rd_reg : (pop_low ? lq_rd_reg : '0);
        res_next.from_low   = pop_low;
        res_next.queue_full = is_push && tgt_full;
        res_next.run_total  = (is_rt && id_ok) ? sum_sat : '0;

        // single write port on the runtime table, shared with the clearing pass
        if (state_reg == tlprs_pkg::ST_CLEAR)
        begin
            rt_we = 1'b1;
            rt_wa = clr_idx_reg;
            rt_wd = '0;
        end
        else
        begin
            rt_we = fire && is_rt && id_ok;
            rt_wa = AW'(item_reg.proc_id);
            rt_wd = sum_sat;
        end

        hq_we = fire && is_push && !tgt_full && item_reg.high_priority;
        lq_we = fire && is_push && !tgt_full && !item_reg.high_priority;

        hhead_next = hhead_reg;
        hcnt_next  = hcnt_reg;
        lhead_next = lhead_reg;
        lcnt_next  = lcnt_reg;
        if (fire)
        begin
            if (hq_we)
            begin
                hcnt_next = hcnt_reg + CW'(1);
            end
            if (lq_we)
            begin
                lcnt_next = lcnt_reg + CW'(1);
            end
            if (pop_high)
            begin
                hcnt_next  = hcnt_reg - CW'(1);
                hhead_next = (hhead_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : hhead_reg + QW'(1);
            end
            if (pop_low)
            begin
                lcnt_next  = lcnt_reg - CW'(1);
                lhead_next = (lhead_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : lhead_reg + QW'(1);
            end
        end

        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlprs_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            hhead_reg     <= '0;
            hcnt_reg      <= '0;
            lhead_reg     <= '0;
            lcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hhead_reg     <= hhead_next;
            hcnt_reg      <= hcnt_next;
            lhead_reg     <= lhead_next;
            lcnt_reg      <= lcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    // runtime table, read on the accepted beat
    always_ff @(posedge clk)
    begin
        if (rt_we)
        begin
            rt_mem[rt_wa] <= rt_wd;
        end
        if (accept)
        begin
            rt_rd_reg <= rt_mem[rd_addr];
        end
    end

    // run queues, heads read on the accepted beat
    always_ff @(posedge clk)
    begin
        if (hq_we)
        begin
            hq_mem[slot] <= item_reg.proc_id;
        end
        if (accept)
        begin
            hq_rd_reg <= hq_mem[hhead_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lq_we)
        begin
            lq_mem[slot] <= item_reg.proc_id;
        end
        if (accept)
        begin
            lq_rd_reg <= lq_mem[lhead_reg];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### tb/tb_two_level_priority_rr_scheduler_core.sv
// testbench for the two-queue priority scheduler core, checked against a behavioral mirror
module tb_two_level_priority_rr_scheduler_core;
    import tlprs_pkg::*;

    class sched_scoreboard;
        // index 1 is the high priority run queue, index 0 the low one
        bit [ID_W-1:0]  run_ids [2][QUEUE_DEPTH_DEF];
        int unsigned    head [2];
        int unsigned    count [2];
        bit [RUN_W-1:0] runtime [MAX_PROCS_DEF];
        result_t        outcomes_due [$];
        int unsigned    fails;

        function bit push_id(bit lvl, bit [ID_W-1:0] id);
            if (count[lvl] >= QUEUE_DEPTH_DEF)
                return 1'b1;
            run_ids[lvl][(head[lvl] + count[lvl]) % QUEUE_DEPTH_DEF] = id;
            count[lvl]++;
            return 1'b0;
        endfunction

        function bit [RUN_W-1:0] add_ticks(bit [ID_W-1:0] id, bit [TICK_W-1:0] ticks);
            bit [RUN_W:0] sum;
            if (id >= MAX_PROCS_DEF)
                return '0;
            sum = {1'b0, runtime[id]} + (RUN_W + 1)'(ticks);
            if (sum[RUN_W])
                sum = {1'b0, {RUN_W{1'b1}}};
            runtime[id] = sum[RUN_W-1:0];
            return sum[RUN_W-1:0];
        endfunction

        function result_t predict(item_t it);
            result_t r;
            bit      lvl;
            r = '0;
            case (it.kind)
                KIND_ENQUEUE:
                    r.queue_full = push_id(it.high_priority, it.proc_id);
                KIND_YIELD:
                begin
                    // runtime still updates when the push is dropped
                    r.run_total  = add_ticks(it.proc_id, it.run_ticks);
                    r.queue_full = push_id(it.high_priority, it.proc_id);
                end
                KIND_BLOCK:
                    r.run_total = add_ticks(it.proc_id, it.run_ticks);
                KIND_SCHEDULE:
                begin
                    lvl = (count[1] != 0);
                    if (count[lvl] != 0)
                    begin
                        r.found     = 1'b1;
                        r.picked_id = run_ids[lvl][head[lvl]];
                        r.from_low  = !lvl;
                        head[lvl]   = (head[lvl] + 1) % QUEUE_DEPTH_DEF;
                        count[lvl]--;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_item(item_t it);
            outcomes_due.push_back(predict(it));
        endfunction

        function void compare(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                fails++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (outcomes_due.size() == 0)
            begin
                fails++;
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                return;
            end
            want = outcomes_due.pop_front();
            compare("found", want.found, got.found);
            compare("picked_id", want.picked_id, got.picked_id);
            compare("from_low", want.from_low, got.from_low);
            compare("queue_full", want.queue_full, got.queue_full);
            compare("run_total", want.run_total, got.run_total);
        endfunction
    endclass

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    bit      calm         = 1'b0;

    sched_scoreboard sb;

    two_level_priority_rr_scheduler_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        result_ready <= calm || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    function automatic item_t mk(kind_t k, bit [ID_W-1:0] id, bit hi, bit [TICK_W-1:0] t);
        item_t it;
        it.kind          = k;
        it.proc_id       = id;
        it.high_priority = hi;
        it.run_ticks     = t;
        return it;
    endfunction

    function automatic bit [TICK_W-1:0] rand_ticks();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t rand_event();
        int    pick;
        kind_t k;
        pick = $urandom_range(99);
        if (pick < 30)
            k = KIND_ENQUEUE;
        else if (pick < 50)
            k = KIND_YIELD;
        else if (pick < 70)
            k = KIND_BLOCK;
        else
            k = KIND_SCHEDULE;
        return mk(k, ID_W'($urandom_range(63)), 1'($urandom_range(1)), rand_ticks());
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send(input item_t it);
        while (!calm && $urandom_range(99) < 23)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(negedge clk);
        while (sb.outcomes_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        #600_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int    n;
        int    burst;
        int    pick;
        bit    lvl;
        bit    paused;
        item_t it;

        sb     = new();
        paused = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // empty queues, both priorities, id and tick extremes
        send(mk(KIND_SCHEDULE, 0, 1'b0, 0));
        send(mk(KIND_ENQUEUE, 0, 1'b0, 0));
        send(mk(KIND_ENQUEUE, 63, 1'b1, '1));
        send(mk(KIND_ENQUEUE, 63, 1'b0, 0));
        send(mk(KIND_YIELD, 0, 1'b1, '1));
        send(mk(KIND_BLOCK, 63, 1'b0, '1));
        send(mk(KIND_BLOCK, 5, 1'b1, 0));
        send(mk(KIND_YIELD, 42, 1'b0, 1));
        repeat (6) send(mk(KIND_SCHEDULE, 0, 1'b0, 0));
        send(mk(KIND_BLOCK, 0, 1'b0, '1));
        send(mk(KIND_ENQUEUE, 21, 1'b1, 32'h5555_5555));
        send(mk(KIND_ENQUEUE, 42, 1'b0, 32'haaaa_aaaa));
        send(mk(KIND_SCHEDULE, 63, 1'b1, '1));
        send(mk(KIND_SCHEDULE, 0, 1'b0, 0));
        wait_drained();

        // back to back maximum ticks on one id, no idling on either side
        calm = 1'b1;
        it = mk(KIND_BLOCK, ID_W'($urandom_range(63)), 1'b0, '1);
        repeat (16) send(it);
        send(mk(KIND_YIELD, it.proc_id, 1'b1, '1));
        send(mk(KIND_SCHEDULE, 0, 1'b0, 0));
        calm = 1'b0;

        n = 0;
        while (n < 850)
        begin
            if (n >= 400 && !paused)
            begin
                wait_drained();
                paused = 1'b1;
            end
            calm = (n >= 550 && n < 650);
            pick = $urandom_range(99);
            if (pick < 7)
            begin
                // push a burst of 60 to 72 ids into one queue, so pushes are dropped once it is full
                lvl   = 1'($urandom_range(1));
                burst = $urandom_range(60, 72);
                repeat (burst)
                    send(mk($urandom_range(1) ? KIND_YIELD : KIND_ENQUEUE,
                            ID_W'($urandom_range(63)), lvl, rand_ticks()));
                n += burst;
            end
            else if (pick < 14)
            begin
                burst = $urandom_range(20, 70);
                repeat (burst)
                    send(mk(KIND_SCHEDULE, ID_W'($urandom_range(63)),
                            1'($urandom_range(1)), rand_ticks()));
                n += burst;
            end
            else
            begin
                send(rand_event());
                n++;
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(negedge clk);
        if (sb.fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
